// ----- sv/hid_keyboard_report_edge_events_core_macros.svh -----
// Assertion macros shared by the keyboard edge-event checker.
// Needs clk_i and rst_ni in the scope that expands them.
`ifndef HID_KEYBOARD_REPORT_EDGE_EVENTS_CORE_MACROS_SVH
`define HID_KEYBOARD_REPORT_EDGE_EVENTS_CORE_MACROS_SVH

// Check out of reset only.
`define HKRE_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included.
`define HKRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/hkre_pkg.sv -----
// Shared types and constants of the keyboard report edge-event block.
// No dependencies.
package hkre_pkg;

  localparam logic       OP_RESET      = 1'b1;
  localparam logic [7:0] MOD_BASE      = 8'hE0;
  localparam int         MAX_MOD_BYTES = 2;
  localparam int         MAX_KEY_SLOTS = 6;

  // One classified request handed from front to back.
  typedef struct packed {
    logic [1:0]                          slot;
    logic [MAX_MOD_BYTES*8-1:0]          mods;
    logic [MAX_KEY_SLOTS-1:0][7:0]       keys;
    logic [MAX_KEY_SLOTS-1:0]            live;
  } job_t;

  // One key event.
  typedef struct packed {
    logic [1:0]  slot;
    logic [15:0] code;
    logic        pressed;
    logic        last_of_run;
  } evt_t;

endpackage

// ----- sv/hkre_fifo.sv -----
// Small register queue used between front and back and at the result side.
// No package dependencies.
module hkre_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNW-1:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- sv/hkre_front.sv -----
// Front end: accepts requests, drops void ones, trims the report to its length.
// Depends on hkre_pkg.
module hkre_front
  import hkre_pkg::*;
#(
  parameter int SLOTS     = 4,
  parameter int MOD_BYTES = 2,
  parameter int KEY_SLOTS = 6
) (
  input  logic       push_i,
  input  logic       job_full_i,
  input  logic       operation_i,
  input  logic [1:0] slot_i,
  input  logic [3:0] report_length_i,
  input  logic [7:0] mod_byte_0_i,
  input  logic [7:0] mod_byte_1_i,
  input  logic [7:0] key_code_0_i,
  input  logic [7:0] key_code_1_i,
  input  logic [7:0] key_code_2_i,
  input  logic [7:0] key_code_3_i,
  input  logic [7:0] key_code_4_i,
  input  logic [7:0] key_code_5_i,
  output job_t       job_o,
  output logic       job_push_o
);

  logic [3:0]                         n_mod_bytes, key_rem, n_key_slots;
  logic [MAX_MOD_BYTES-1:0][7:0]      mod_in;
  logic [MAX_KEY_SLOTS-1:0][7:0]      key_in;
  logic                               keep, chain;

  assign mod_in = {mod_byte_1_i, mod_byte_0_i};
  assign key_in = {key_code_5_i, key_code_4_i, key_code_3_i,
                   key_code_2_i, key_code_1_i, key_code_0_i};

  always_comb begin
    n_mod_bytes = (report_length_i < 4'(MOD_BYTES)) ? report_length_i : 4'(MOD_BYTES);
    key_rem     = report_length_i - n_mod_bytes;
    n_key_slots = (key_rem > 4'(KEY_SLOTS)) ? 4'(KEY_SLOTS) : key_rem;
    // A slot reset looks like an all-zero report: everything held gets released.
    if (operation_i == OP_RESET) begin
      n_mod_bytes = '0;
      n_key_slots = '0;
    end

    job_o.slot = slot_i;
    for (int m = 0; m < MAX_MOD_BYTES; m++) begin
      job_o.mods[m*8 +: 8] = (4'(m) < n_mod_bytes) ? mod_in[m] : 8'h00;
    end
    chain = 1'b1;
    for (int i = 0; i < MAX_KEY_SLOTS; i++) begin
      job_o.keys[i] = (4'(i) < n_key_slots) ? key_in[i] : 8'h00;
      chain         = chain && (job_o.keys[i] != 8'h00);
      job_o.live[i] = chain;
    end

    keep = (32'(slot_i) < SLOTS) &&
           ((operation_i == OP_RESET) || (report_length_i != 4'd0));
  end

  assign job_push_o = push_i && !job_full_i && keep;

endmodule

// ----- sv/hkre_back.sv -----
// Back end: per-slot history and the event sequencer, one candidate per cycle unless the result queue is full.
// Depends on hkre_pkg.
module hkre_back
  import hkre_pkg::*;
#(
  parameter int SLOTS     = 4,
  parameter int MOD_BYTES = 2,
  parameter int KEY_SLOTS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_t        job_i,
  input  logic        job_empty_i,
  output logic        job_pop_o,
  input  logic [15:0] prefix_i,
  output evt_t        evt_o,
  output logic        evt_push_o,
  input  logic        evt_full_i
);

  localparam int MODBITS = MOD_BYTES * 8;
  localparam int NSTEP   = MODBITS + 2 * KEY_SLOTS;
  localparam int CW      = $clog2(NSTEP);
  localparam int MBW     = $clog2(MODBITS);
  localparam int KW      = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // Per-slot history.
  logic [MODBITS-1:0] mods_mem_q [SLOTS];
  logic [7:0]         keys_mem_q [SLOTS][KEY_SLOTS];

  // Working copy of the request being sequenced.
  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [1:0]          slot_q;
  logic [MODBITS-1:0]  cur_mods_q, prev_mods_q;
  logic [7:0]          cur_keys_q [KEY_SLOTS];
  logic [7:0]          prev_keys_q [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] cur_live_q, prev_live_q, row_live;
  evt_t                pend_q, cand;
  logic                pend_valid_q, pend_valid_d, pend_load, pend_clr;

  logic [SW-1:0]  sidx;
  logic [CW-1:0]  pidx_full, ridx_full;
  logic [KW-1:0]  kidx_p, kidx_r;
  logic [MBW-1:0] mbit;
  logic           in_mod, in_press, prev_has, cur_has, hit, chain;
  logic [7:0]     code8;

  assign sidx = SW'(job_i.slot);

  // Live flags of the stored list: valid up to its first zero.
  always_comb begin
    chain = 1'b1;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      chain       = chain && (keys_mem_q[sidx][j] != 8'h00);
      row_live[j] = chain;
    end
  end

  // Decode the current step: modifier bit, press candidate or release candidate.
  always_comb begin
    pidx_full = cnt_q - CW'(MODBITS);
    ridx_full = cnt_q - CW'(MODBITS + KEY_SLOTS);
    kidx_p    = pidx_full[KW-1:0];
    kidx_r    = ridx_full[KW-1:0];
    mbit      = cnt_q[MBW-1:0];
    in_mod    = cnt_q < CW'(MODBITS);
    in_press  = !in_mod && (cnt_q < CW'(MODBITS + KEY_SLOTS));
    prev_has  = 1'b0;
    cur_has   = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (prev_live_q[j] && (prev_keys_q[j] == cur_keys_q[kidx_p])) begin
        prev_has = 1'b1;
      end
      if (cur_live_q[j] && (cur_keys_q[j] == prev_keys_q[kidx_r])) begin
        cur_has = 1'b1;
      end
    end
    if (in_mod) begin
      hit   = cur_mods_q[mbit] ^ prev_mods_q[mbit];
      code8 = MOD_BASE + 8'(cnt_q);
    end else if (in_press) begin
      hit   = cur_live_q[kidx_p] && !prev_has;
      code8 = cur_keys_q[kidx_p];
    end else begin
      hit   = prev_live_q[kidx_r] && !cur_has;
      code8 = prev_keys_q[kidx_r];
    end
    cand.slot        = slot_q;
    cand.code        = prefix_i | {8'h00, code8};
    cand.pressed     = in_mod ? cur_mods_q[mbit] : in_press;
    cand.last_of_run = 1'b0;
  end

  // Sequencer. One event waits in the pending register until the next one
  // shows up, so the final event of a request can be flagged.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    job_pop_o  = 1'b0;
    evt_push_o = 1'b0;
    pend_load  = 1'b0;
    pend_clr   = 1'b0;
    evt_o      = pend_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          cnt_d     = '0;
          state_d   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!(hit && pend_valid_q && evt_full_i)) begin
          if (hit) begin
            evt_push_o = pend_valid_q;
            pend_load  = 1'b1;
          end
          if (cnt_q == CW'(NSTEP - 1)) begin
            state_d = ST_FLUSH;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        evt_o.last_of_run = 1'b1;
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (!evt_full_i) begin
          evt_push_o = 1'b1;
          pend_clr   = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    pend_valid_d = pend_load ? 1'b1 : (pend_clr ? 1'b0 : pend_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        mods_mem_q[s] <= '0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
          keys_mem_q[s][j] <= 8'h00;
        end
      end
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      // The working copy keeps the old history, so store the new one at once.
      if (job_pop_o) begin
        mods_mem_q[sidx] <= job_i.mods[MODBITS-1:0];
        for (int j = 0; j < KEY_SLOTS; j++) begin
          keys_mem_q[sidx][j] <= job_i.keys[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      slot_q      <= job_i.slot;
      cur_mods_q  <= job_i.mods[MODBITS-1:0];
      prev_mods_q <= mods_mem_q[sidx];
      cur_live_q  <= job_i.live[KEY_SLOTS-1:0];
      prev_live_q <= row_live;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        cur_keys_q[j]  <= job_i.keys[j];
        prev_keys_q[j] <= keys_mem_q[sidx][j];
      end
    end
    if (pend_load) begin
      pend_q <= cand;
    end
  end

endmodule

// ----- sv/hid_keyboard_report_edge_events_core.sv -----
// The back end examines one candidate event per cycle: each modifier bit, then each key
// slot as a press and as a release; a stalled result side adds wait.
// The front takes new requests while the back works, up to the job queue depth.
// Reset (async, active low) clears all slot history, the prefix and both queues at
// once; no clearing pass follows.
module hid_keyboard_report_edge_events_core
  import hkre_pkg::*;
#(
  parameter int SLOTS     = 4,
  parameter int MOD_BYTES = 2,
  parameter int KEY_SLOTS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request side.
  input  logic        push,
  output logic        full,
  input  logic        operation_i,
  input  logic [1:0]  slot_i,
  input  logic [3:0]  report_length_i,
  input  logic [7:0]  mod_byte_0_i,
  input  logic [7:0]  mod_byte_1_i,
  input  logic [7:0]  key_code_0_i,
  input  logic [7:0]  key_code_1_i,
  input  logic [7:0]  key_code_2_i,
  input  logic [7:0]  key_code_3_i,
  input  logic [7:0]  key_code_4_i,
  input  logic [7:0]  key_code_5_i,
  // Configuration.
  input  logic        keyboard_code_prefix_we_i,
  input  logic [15:0] keyboard_code_prefix_i,
  // Event side.
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  event_slot_o,
  output logic [15:0] event_code_o,
  output logic        pressed_o,
  output logic        last_of_run_o
);

  localparam int JOB_DEPTH = 2;
  localparam int EVT_DEPTH = 2;

  logic [15:0] prefix_q;
  job_t        job_in, job_out;
  logic        job_push, job_pop, job_full, job_empty;
  evt_t        evt_in, evt_out;
  logic        evt_push, evt_full;

  // Prefix register: the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= 16'h0000;
    end else if (keyboard_code_prefix_we_i) begin
      prefix_q <= keyboard_code_prefix_i;
    end
  end

  // Classify each request: drop void ones, trim the report to its length.
  hkre_front #(
    .SLOTS     (SLOTS),
    .MOD_BYTES (MOD_BYTES),
    .KEY_SLOTS (KEY_SLOTS)
  ) u_front (
    .push_i          (push),
    .job_full_i      (job_full),
    .operation_i     (operation_i),
    .slot_i          (slot_i),
    .report_length_i (report_length_i),
    .mod_byte_0_i    (mod_byte_0_i),
    .mod_byte_1_i    (mod_byte_1_i),
    .key_code_0_i    (key_code_0_i),
    .key_code_1_i    (key_code_1_i),
    .key_code_2_i    (key_code_2_i),
    .key_code_3_i    (key_code_3_i),
    .key_code_4_i    (key_code_4_i),
    .key_code_5_i    (key_code_5_i),
    .job_o           (job_in),
    .job_push_o      (job_push)
  );

  // Hold classified requests so the front keeps accepting while the back runs.
  hkre_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // A request is taken whenever the job queue has room, void ones included.
  assign full = job_full;

  // Walk modifier bits, presses, then releases; keep slot history.
  hkre_back #(
    .SLOTS     (SLOTS),
    .MOD_BYTES (MOD_BYTES),
    .KEY_SLOTS (KEY_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .prefix_i    (prefix_q),
    .evt_o       (evt_in),
    .evt_push_o  (evt_push),
    .evt_full_i  (evt_full)
  );

  // Result queue: the oldest event sits on the ports while empty is low.
  hkre_fifo #(
    .WIDTH ($bits(evt_t)),
    .DEPTH (EVT_DEPTH)
  ) u_evt_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (evt_push),
    .data_i  (evt_in),
    .full_o  (evt_full),
    .pop_i   (pop),
    .data_o  (evt_out),
    .empty_o (empty)
  );

  assign event_slot_o  = evt_out.slot;
  assign event_code_o  = evt_out.code;
  assign pressed_o     = evt_out.pressed;
  assign last_of_run_o = evt_out.last_of_run;

endmodule

// ----- sv/hkre_checker.sv -----
// Port-level checks for the keyboard edge-event core, bound to the top level.
// Depends on hid_keyboard_report_edge_events_core_macros.svh.
`include "hid_keyboard_report_edge_events_core_macros.svh"

module hkre_checker #(
  parameter int SLOTS = 4
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  event_slot_o,
  input logic [15:0] event_code_o,
  input logic        pressed_o,
  input logic        last_of_run_o
);

  // Both queues come out of reset drained.
  `HKRE_ASSERT_ALWAYS(a_reset_drained, !rst_ni |-> (empty && !full), "queues not drained in reset")

  // An unpopped event stays put.
  `HKRE_ASSERT_RUN(a_hold_event, (!empty && !pop) |=> (!empty && $stable(event_slot_o) && $stable(event_code_o) && $stable(pressed_o) && $stable(last_of_run_o)), "waiting event changed")

  // Events only ever name a slot that exists.
  `HKRE_ASSERT_RUN(a_slot_range, !empty |-> (32'(event_slot_o) < SLOTS), "event names a missing slot")

endmodule

bind hid_keyboard_report_edge_events_core hkre_checker #(.SLOTS(SLOTS)) u_hkre_checker (.*);

// ----- sim/tb_hid_keyboard_report_edge_events_core.sv -----
// Self-checking testbench for hid_keyboard_report_edge_events_core.
// Predicts the key and modifier edge events of every request and checks each
// popped event in order. Depends on hkre_pkg and the core module only.
module tb_hid_keyboard_report_edge_events_core;
  import hkre_pkg::*;

  localparam int  SLOTS         = 4;
  localparam int  MOD_BYTES     = 2;
  localparam int  KEY_SLOTS     = 6;
  localparam logic OP_REPORT    = 1'b0;
  localparam int  WATCHDOG_MAX  = 5000;
  localparam int  SETTLE_CYCLES = 200;
  localparam int  REPORT_LIMIT  = 10;

  // One request as seen on the request ports.
  typedef struct packed {
    logic                  op;
    logic [1:0]            slot;
    logic [3:0]            report_length;
    logic [1:0][7:0]       mods;
    logic [5:0][7:0]       keys;
  } kbd_request_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        operation_i;
  logic [1:0]  slot_i;
  logic [3:0]  report_length_i;
  logic [7:0]  mod_byte_0_i;
  logic [7:0]  mod_byte_1_i;
  logic [7:0]  key_code_0_i;
  logic [7:0]  key_code_1_i;
  logic [7:0]  key_code_2_i;
  logic [7:0]  key_code_3_i;
  logic [7:0]  key_code_4_i;
  logic [7:0]  key_code_5_i;
  logic        keyboard_code_prefix_we_i;
  logic [15:0] keyboard_code_prefix_i;
  logic        empty;
  logic        pop;
  logic [1:0]  event_slot_o;
  logic [15:0] event_code_o;
  logic        pressed_o;
  logic        last_of_run_o;

  // Shadow of the block state used by the event predictor.
  logic [15:0]           prefix_shadow;
  logic [1:0][7:0]       held_mods [SLOTS];
  logic [5:0][7:0]       held_keys [SLOTS];

  // Events predicted but not yet popped, oldest first.
  evt_t expected_events[$];

  int   fail_count;
  int   idle_cycles;
  bit   quiet_mode;
  int   pop_stall;

  hid_keyboard_report_edge_events_core #(
    .SLOTS     (SLOTS),
    .MOD_BYTES (MOD_BYTES),
    .KEY_SLOTS (KEY_SLOTS)
  ) DUT (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .push                      (push),
    .full                      (full),
    .operation_i               (operation_i),
    .slot_i                    (slot_i),
    .report_length_i           (report_length_i),
    .mod_byte_0_i              (mod_byte_0_i),
    .mod_byte_1_i              (mod_byte_1_i),
    .key_code_0_i              (key_code_0_i),
    .key_code_1_i              (key_code_1_i),
    .key_code_2_i              (key_code_2_i),
    .key_code_3_i              (key_code_3_i),
    .key_code_4_i              (key_code_4_i),
    .key_code_5_i              (key_code_5_i),
    .keyboard_code_prefix_we_i (keyboard_code_prefix_we_i),
    .keyboard_code_prefix_i    (keyboard_code_prefix_i),
    .empty                     (empty),
    .pop                       (pop),
    .event_slot_o              (event_slot_o),
    .event_code_o              (event_code_o),
    .pressed_o                 (pressed_o),
    .last_of_run_o             (last_of_run_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Event predictor
  // ---------------------------------------------------------------------------

  // Scan a key list up to its first zero, limited to count entries.
  function automatic bit key_in_list(logic [5:0][7:0] list, int count, logic [7:0] key);
    for (int i = 0; i < count && list[i] != 8'h00; i++) begin
      if (list[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Append one event; the prefix is ORed over the zero-extended code.
  function automatic int add_event(int n, logic [1:0] slot, logic [7:0] code, logic down);
    evt_t ev;
    ev.slot        = slot;
    ev.code        = prefix_shadow | {8'h00, code};
    ev.pressed     = down;
    ev.last_of_run = 1'b0;
    expected_events.push_back(ev);
    return n + 1;
  endfunction

  // Work out the events of one accepted request and advance the shadow state.
  function automatic void predict_events(kbd_request_t r);
    int              n;
    int              n_mods;
    int              n_keys;
    logic [7:0]      cur;
    logic [7:0]      changed;
    logic [5:0][7:0] old_keys;
    evt_t            ev;
    n = 0;
    old_keys = held_keys[r.slot];
    if (r.op == OP_RESET) begin
      // Release every held modifier bit, then every held key, then clear.
      for (int m = 0; m < MOD_BYTES; m++) begin
        for (int b = 0; b < 8; b++) begin
          if (held_mods[r.slot][m][b])
            n = add_event(n, r.slot, 8'(MOD_BASE + 8 * m + b), 1'b0);
        end
      end
      for (int i = 0; i < KEY_SLOTS && old_keys[i] != 8'h00; i++)
        n = add_event(n, r.slot, old_keys[i], 1'b0);
      held_mods[r.slot] = '0;
      held_keys[r.slot] = '0;
    end else begin
      // An empty report leaves everything untouched.
      if (r.report_length == 4'd0) return;
      n_mods = (r.report_length < MOD_BYTES) ? int'(r.report_length) : MOD_BYTES;
      n_keys = int'(r.report_length) - n_mods;
      if (n_keys > KEY_SLOTS) n_keys = KEY_SLOTS;
      for (int m = 0; m < MOD_BYTES; m++) begin
        cur     = (m < n_mods) ? r.mods[m] : 8'h00;
        changed = cur ^ held_mods[r.slot][m];
        for (int b = 0; b < 8; b++) begin
          if (changed[b])
            n = add_event(n, r.slot, 8'(MOD_BASE + 8 * m + b), cur[b]);
        end
        held_mods[r.slot][m] = cur;
      end
      for (int i = 0; i < n_keys && r.keys[i] != 8'h00; i++) begin
        if (!key_in_list(old_keys, KEY_SLOTS, r.keys[i]))
          n = add_event(n, r.slot, r.keys[i], 1'b1);
      end
      for (int i = 0; i < KEY_SLOTS && old_keys[i] != 8'h00; i++) begin
        if (!key_in_list(r.keys, n_keys, old_keys[i]))
          n = add_event(n, r.slot, old_keys[i], 1'b0);
      end
      // Keep the valid key slots verbatim, zeros and all.
      held_keys[r.slot] = '0;
      for (int i = 0; i < n_keys; i++) held_keys[r.slot][i] = r.keys[i];
    end
    // Flag the final event of this request.
    if (n > 0) begin
      ev = expected_events.pop_back();
      ev.last_of_run = 1'b1;
      expected_events.push_back(ev);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Gap before a request: mostly none or short, now and then long.
  function automatic int request_gap();
    int pick;
    if (quiet_mode) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // mods is {mod_byte_1, mod_byte_0}; keys is {key_code_5, ..., key_code_0}.
  function automatic kbd_request_t mk_request(logic op, logic [1:0] slot, logic [3:0] len,
                                              logic [15:0] mods, logic [47:0] keys);
    kbd_request_t r;
    r.op            = op;
    r.slot          = slot;
    r.report_length = len;
    r.mods          = mods;
    r.keys          = keys;
    return r;
  endfunction

  // Present one request and hold it until the block takes it. Push stays high
  // after acceptance so that back-to-back requests need no toggle.
  task automatic send_request(kbd_request_t r);
    int gap;
    gap = request_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    operation_i     <= r.op;
    slot_i          <= r.slot;
    report_length_i <= r.report_length;
    mod_byte_0_i    <= r.mods[0];
    mod_byte_1_i    <= r.mods[1];
    key_code_0_i    <= r.keys[0];
    key_code_1_i    <= r.keys[1];
    key_code_2_i    <= r.keys[2];
    key_code_3_i    <= r.keys[3];
    key_code_4_i    <= r.keys[4];
    key_code_5_i    <= r.keys[5];
    push            <= 1'b1;
    do @(posedge clk_i); while (full);
    predict_events(r);
  endtask

  // Drop push, wait out every expected event, then let the back end settle on
  // any request that produced no events.
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the code prefix while the block is idle.
  task automatic set_code_prefix(logic [15:0] value);
    wait_drained();
    keyboard_code_prefix_we_i <= 1'b1;
    keyboard_code_prefix_i    <= value;
    @(posedge clk_i);
    keyboard_code_prefix_we_i <= 1'b0;
    prefix_shadow = value;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random pop stalls, mostly short, a few long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall--;
    end else if (!quiet_mode && $urandom_range(0, 99) < 25) begin
      pop <= 1'b0;
      pop_stall = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                               : $urandom_range(10, 80);
    end else begin
      pop <= 1'b1;
    end
  end

  // Compare each popped event against the oldest prediction; also run the
  // watchdog on cycles where neither side moves a request or an event.
  always @(posedge clk_i) begin
    evt_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_events.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected event: slot %0d code %h pressed %0b last %0b",
                   event_slot_o, event_code_o, pressed_o, last_of_run_o);
      end else begin
        want = expected_events.pop_front();
        if (want.slot !== event_slot_o || want.code !== event_code_o ||
            want.pressed !== pressed_o || want.last_of_run !== last_of_run_o) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("event mismatch: expected slot %0d code %h pressed %0b last %0b, %s",
                     want.slot, want.code, want.pressed, want.last_of_run,
                     $sformatf("got slot %0d code %h pressed %0b last %0b",
                               event_slot_o, event_code_o, pressed_o, last_of_run_o));
        end
      end
    end
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("tb_hid_keyboard_report_edge_events_core failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All modifiers and six keys down, repeat, all up; then the widest change.
  task automatic test_modifier_and_key_edges();
    send_request(mk_request(OP_REPORT, 2'd0, 4'd8, 16'hFFFF, 48'h09_08_07_06_05_04));
    send_request(mk_request(OP_REPORT, 2'd0, 4'd8, 16'hFFFF, 48'h09_08_07_06_05_04));
    send_request(mk_request(OP_REPORT, 2'd0, 4'd8, 16'h0000, 48'h00_00_00_00_00_00));
    send_request(mk_request(OP_REPORT, 2'd1, 4'd8, 16'h0000, 48'h09_08_07_06_05_04));
    // Sixteen modifier presses, six key presses and six releases at once.
    send_request(mk_request(OP_REPORT, 2'd1, 4'd8, 16'hFFFF, 48'hFF_0F_0E_0D_0C_0B));
    send_request(mk_request(OP_REPORT, 2'd3, 4'd8, 16'hA55A, 48'h00_00_00_01_80_FE));
  endtask

  // Empty, short, partial and overlong reports on one slot.
  task automatic test_report_lengths();
    send_request(mk_request(OP_REPORT, 2'd2, 4'd0, 16'hFFFF, 48'h09_08_07_06_05_04));
    send_request(mk_request(OP_REPORT, 2'd2, 4'd1, 16'hFF81, 48'h09_08_07_06_05_04));
    send_request(mk_request(OP_REPORT, 2'd2, 4'd2, 16'h4200, 48'h00_00_00_00_00_04));
    send_request(mk_request(OP_REPORT, 2'd2, 4'd3, 16'h4200, 48'h00_00_00_06_05_04));
    send_request(mk_request(OP_REPORT, 2'd2, 4'd15, 16'h0000, 48'h0A_09_08_07_06_05));
    send_request(mk_request(OP_REPORT, 2'd2, 4'd5, 16'h0001, 48'h0A_09_08_07_06_05));
  endtask

  // Keys past a zero are stored but ignored; a repeated new key presses twice.
  task automatic test_key_list_rules();
    send_request(mk_request(OP_REPORT, 2'd0, 4'd8, 16'h0000, 48'h00_00_06_05_00_04));
    send_request(mk_request(OP_REPORT, 2'd0, 4'd8, 16'h0000, 48'h00_00_00_00_00_05));
    send_request(mk_request(OP_REPORT, 2'd0, 4'd8, 16'h0000, 48'h00_00_00_07_07_05));
    send_request(mk_request(OP_REPORT, 2'd0, 4'd8, 16'h0000, 48'h00_00_00_00_00_00));
  endtask

  // Slot reset releases everything held; length and bytes are don't-care.
  task automatic test_slot_reset();
    send_request(mk_request(OP_RESET, 2'd1, 4'd0, 16'h1234, 48'h11_22_33_44_55_66));
    send_request(mk_request(OP_RESET, 2'd1, 4'd8, 16'hFFFF, 48'hFF_FF_FF_FF_FF_FF));
    send_request(mk_request(OP_RESET, 2'd3, 4'd15, 16'h5AA5, 48'h00_00_00_00_00_00));
    send_request(mk_request(OP_REPORT, 2'd3, 4'd3, 16'h0001, 48'h00_00_00_00_00_04));
  endtask

  // Build a plausible next report for a slot: evolve the held state, reuse
  // held keys often so presses and releases mix. Some requests are noise.
  function automatic kbd_request_t next_typing_request();
    kbd_request_t r;
    int           kind;
    int           count;
    r      = kbd_request_t'({$urandom, $urandom, $urandom});
    kind   = $urandom_range(0, 99);
    if (kind < 15) return r;
    r.op   = ($urandom_range(0, 99) < 8) ? OP_RESET : OP_REPORT;
    r.report_length = ($urandom_range(0, 99) < 80) ? 4'd8 : 4'($urandom_range(0, 15));
    r.mods = held_mods[r.slot];
    if ($urandom_range(0, 1) == 1) r.mods = r.mods ^ (16'h1 << $urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) r.mods = 16'($urandom);
    count  = $urandom_range(0, KEY_SLOTS);
    r.keys = '0;
    for (int i = 0; i < count; i++) begin
      if (held_keys[r.slot][i] != 8'h00 && $urandom_range(0, 99) < 60)
        r.keys[i] = held_keys[r.slot][i];
      else if ($urandom_range(0, 9) == 0)
        r.keys[i] = 8'($urandom_range(1, 255));
      else
        r.keys[i] = 8'($urandom_range(4, 40));
    end
    return r;
  endfunction

  task automatic test_random_typing(int count);
    for (int i = 0; i < count; i++) send_request(next_typing_request());
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni                    = 1'b0;
    push                      = 1'b0;
    pop                       = 1'b0;
    operation_i               = 1'b0;
    slot_i                    = '0;
    report_length_i           = '0;
    mod_byte_0_i              = '0;
    mod_byte_1_i              = '0;
    key_code_0_i              = '0;
    key_code_1_i              = '0;
    key_code_2_i              = '0;
    key_code_3_i              = '0;
    key_code_4_i              = '0;
    key_code_5_i              = '0;
    keyboard_code_prefix_we_i = 1'b0;
    keyboard_code_prefix_i    = '0;
    prefix_shadow             = '0;
    fail_count                = 0;
    idle_cycles               = 0;
    quiet_mode                = 1'b0;
    pop_stall                 = 0;
    for (int s = 0; s < SLOTS; s++) begin
      held_mods[s] = '0;
      held_keys[s] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Prefix stays at its reset value for the first phase.
    test_modifier_and_key_edges();
    set_code_prefix(16'hFFFF);
    test_report_lengths();
    set_code_prefix(16'h0A00);
    test_key_list_rules();
    test_slot_reset();
    set_code_prefix(16'($urandom));
    test_random_typing(70);
    // Run a stretch with no idling on either side.
    set_code_prefix(16'h0000);
    quiet_mode = 1'b1;
    test_random_typing(30);
    quiet_mode = 1'b0;
    set_code_prefix(16'h8000);
    test_random_typing(60);

    wait_drained();
    if (expected_events.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("tb_hid_keyboard_report_edge_events_core passed");
    end else begin
      $display("tb_hid_keyboard_report_edge_events_core failed");
    end
    $finish;
  end

endmodule
